@@ rtl/overwriting_byte_ring_buffer_defines.svh @@
// ----------------------------------------------------------------------------
// Overwriting byte ring buffer: assertion macros
// Shared concurrent assertion forms for the buffer's checkers.
// ----------------------------------------------------------------------------
`ifndef OVERWRITING_BYTE_RING_BUFFER_DEFINES_SVH
`define OVERWRITING_BYTE_RING_BUFFER_DEFINES_SVH

// Check a property on every rising edge of clk outside reset.
`define OBRB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge of clk, reset included.
`define OBRB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/obrb_pkg.sv @@
// ----------------------------------------------------------------------------
// obrb_pkg
// Types and constants shared by the overwriting byte ring buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package obrb_pkg;

  localparam int CAPACITY_DEF  = 1024;
  localparam int MAX_BURST_DEF = 64;

  localparam int MODE_W  = 2;
  localparam int BYTE_W  = 8;
  localparam int LEN_IN_W = 7;
  localparam int FILL_W  = 11;

  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [BYTE_W-1:0]   data_byte;
    logic [LEN_IN_W-1:0] max_len;
  } cmd_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_byte;
    logic              byte_valid;
    logic              last;
    logic [FILL_W-1:0] fill_level;
  } result_t;

  typedef enum logic {
    ST_IDLE,
    ST_BURST
  } state_t;

endpackage

`default_nettype wire

@@ rtl/obrb_ram.sv @@
// ----------------------------------------------------------------------------
// obrb_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module obrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/overwriting_byte_ring_buffer.sv @@
// A byte ring buffer whose writer never waits: a write stores one byte and,
// when the buffer is full, drops the oldest byte. A command is taken when
// start is high and busy is low. Write, clear and unused commands give no
// result. A read of n bytes (n = min(fill, max_len, MAX_BURST)) issues one
// read of the byte RAM per cycle, so busy stays high through the last such
// read; results leave on strobe one per cycle, each in the cycle after its
// RAM read, the last one marked. A read with nothing to give returns one
// invalid result in the next cycle. The next command may be taken in the
// cycle that shows the final result. The receiver cannot hold results off:
// each is on the result port for exactly one cycle.
// ----------------------------------------------------------------------------
// overwriting_byte_ring_buffer
// Top level: command decode, index and fill bookkeeping, burst sequencing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module overwriting_byte_ring_buffer
  import obrb_pkg::*;
#(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int MAX_BURST = MAX_BURST_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  input  wire cmd_t    cmd,
  output logic         busy,
  output logic         strobe,
  output result_t      result
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int LEN_W = $clog2(MAX_BURST + 1);
  localparam int CMP_W = (CNT_W > LEN_IN_W) ? CNT_W : LEN_IN_W;

  localparam logic [IDX_W-1:0]    LAST_SLOT = IDX_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0]    FULL      = CNT_W'(CAPACITY);
  localparam logic [LEN_IN_W-1:0] BURST_CAP = LEN_IN_W'(MAX_BURST);

  state_t state, state_next;

  logic [IDX_W-1:0] write_index, write_index_next;
  logic [IDX_W-1:0] read_index, read_index_next;
  logic [CNT_W-1:0] fill, fill_next;
  logic [LEN_W-1:0] remaining, remaining_next;
  logic             pend, pend_next;
  logic             pend_valid, pend_valid_next;
  logic             pend_last, pend_last_next;
  logic [CNT_W-1:0] pend_fill, pend_fill_next;

  logic                accept;
  logic [LEN_IN_W-1:0] want;
  logic [CMP_W-1:0]    fill_x;
  logic [CMP_W-1:0]    want_x;
  logic [CMP_W-1:0]    n_cmp;
  logic                wr_en;
  logic                rd_en;
  logic [BYTE_W-1:0]   ram_q;

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] slot);
    next_slot = (slot == LAST_SLOT) ? '0 : slot + IDX_W'(1);
  endfunction

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  assign want   = (cmd.max_len > BURST_CAP) ? BURST_CAP : cmd.max_len;
  assign fill_x = CMP_W'(fill);
  assign want_x = CMP_W'(want);
  assign n_cmp  = (fill_x < want_x) ? fill_x : want_x;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && cmd.mode == MODE_READ && n_cmp > CMP_W'(1)) begin
          state_next = ST_BURST;
        end
      end
      ST_BURST: begin
        if (remaining == LEN_W'(1)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath and RAM control.
  always_comb begin
    wr_en            = 1'b0;
    rd_en            = 1'b0;
    write_index_next = write_index;
    read_index_next  = read_index;
    fill_next        = fill;
    remaining_next   = remaining;
    pend_next        = 1'b0;
    pend_valid_next  = 1'b0;
    pend_last_next   = 1'b0;
    pend_fill_next   = pend_fill;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (cmd.mode)
            MODE_WRITE: begin
              wr_en            = 1'b1;
              write_index_next = next_slot(write_index);
              if (fill == FULL) begin
                read_index_next = next_slot(read_index);
              end else begin
                fill_next = fill + CNT_W'(1);
              end
            end
            MODE_READ: begin
              pend_next = 1'b1;
              if (n_cmp == '0) begin
                pend_last_next = 1'b1;
                pend_fill_next = fill;
              end else begin
                rd_en           = 1'b1;
                read_index_next = next_slot(read_index);
                fill_next       = fill - CNT_W'(1);
                remaining_next  = LEN_W'(n_cmp - CMP_W'(1));
                pend_valid_next = 1'b1;
                pend_last_next  = (n_cmp == CMP_W'(1));
                pend_fill_next  = fill - CNT_W'(1);
              end
            end
            MODE_CLEAR: begin
              write_index_next = '0;
              read_index_next  = '0;
              fill_next        = '0;
            end
            default: ;
          endcase
        end
      end
      ST_BURST: begin
        rd_en           = 1'b1;
        read_index_next = next_slot(read_index);
        fill_next       = fill - CNT_W'(1);
        remaining_next  = remaining - LEN_W'(1);
        pend_next       = 1'b1;
        pend_valid_next = 1'b1;
        pend_last_next  = (remaining == LEN_W'(1));
        pend_fill_next  = fill - CNT_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      write_index <= '0;
      read_index  <= '0;
      fill        <= '0;
      pend        <= 1'b0;
    end else begin
      state       <= state_next;
      write_index <= write_index_next;
      read_index  <= read_index_next;
      fill        <= fill_next;
      pend        <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    remaining  <= remaining_next;
    pend_valid <= pend_valid_next;
    pend_last  <= pend_last_next;
    pend_fill  <= pend_fill_next;
  end

  obrb_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(write_index),
    .wr_data(cmd.data_byte),
    .rd_en  (rd_en),
    .rd_addr(read_index),
    .rd_data(ram_q)
  );

  assign strobe            = pend;
  assign result.read_byte  = pend_valid ? ram_q : '0;
  assign result.byte_valid = pend_valid;
  assign result.last       = pend_last;
  assign result.fill_level = FILL_W'(pend_fill);

endmodule

`default_nettype wire

@@ rtl/obrb_checker.sv @@
// ----------------------------------------------------------------------------
// obrb_checker
// Port-level checks on the result stream of the overwriting byte ring buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "overwriting_byte_ring_buffer_defines.svh"

module obrb_checker
  import obrb_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    busy,
  input wire logic    strobe,
  input wire result_t result
);

  `OBRB_ASSERT(a_empty_is_last,
    strobe && !result.byte_valid |-> result.last,
    "empty reply not marked last")
  `OBRB_ASSERT(a_empty_zero,
    strobe && !result.byte_valid |-> result.read_byte == '0,
    "empty reply carries data")
  `OBRB_ASSERT(a_burst_gapless,
    strobe && !result.last |=> strobe && result.byte_valid,
    "burst broken")
  `OBRB_ASSERT(a_busy_in_burst,
    strobe && !result.last |-> busy,
    "command port open inside burst")
  `OBRB_ASSERT(a_fill_drops,
    strobe && !result.last |=> result.fill_level == $past(result.fill_level) - 11'd1,
    "fill level does not drop by one per byte")

endmodule

bind overwriting_byte_ring_buffer obrb_checker u_obrb_checker (.*);

`default_nettype wire

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the overwriting byte ring buffer. A ring model in
// the bench tracks every accepted command and queues the results it must
// produce. Directed tests cover empty and zero-length reads, saturated burst
// length, the unused mode, overwrite of the oldest byte when full, and clear.
// Random traffic then runs under several sender idle rates. Each strobed
// result is compared field by field with the oldest queued result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import obrb_pkg::*;

  localparam int               RING_DEPTH  = CAPACITY_DEF;
  localparam int               BURST_LIMIT = MAX_BURST_DEF;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  logic    clk;
  logic    rst;
  logic    start;
  cmd_t    cmd;
  logic    busy;
  logic    strobe;
  result_t result;

  logic [BYTE_W-1:0] ring_bytes [RING_DEPTH];
  int                ring_wr;
  int                ring_rd;
  int                ring_fill;
  result_t           awaited_results [$];
  int                mismatch_count;
  int                idle_pct;

  overwriting_byte_ring_buffer u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("Mismatches found");
    $finish;
  end

  function automatic int next_slot(input int slot);
    return (slot == RING_DEPTH - 1) ? 0 : slot + 1;
  endfunction

  function automatic void apply_cmd_to_ring(input cmd_t c);
    int want;
    int n;
    result_t r;
    case (c.mode)
      MODE_WRITE: begin
        ring_bytes[ring_wr] = c.data_byte;
        ring_wr = next_slot(ring_wr);
        if (ring_fill == RING_DEPTH) begin
          ring_rd = next_slot(ring_rd);
        end else begin
          ring_fill++;
        end
      end
      MODE_CLEAR: begin
        ring_wr   = 0;
        ring_rd   = 0;
        ring_fill = 0;
      end
      MODE_READ: begin
        want = (c.max_len > BURST_LIMIT) ? BURST_LIMIT : int'(c.max_len);
        n    = (ring_fill < want) ? ring_fill : want;
        if (n == 0) begin
          r = '{read_byte: '0, byte_valid: 1'b0, last: 1'b1,
                fill_level: FILL_W'(ring_fill)};
          awaited_results.push_back(r);
        end
        for (int i = 0; i < n; i++) begin
          r.read_byte = ring_bytes[ring_rd];
          ring_rd = next_slot(ring_rd);
          ring_fill--;
          r.byte_valid = 1'b1;
          r.last       = (i == n - 1);
          r.fill_level = FILL_W'(ring_fill);
          awaited_results.push_back(r);
        end
      end
      default: begin
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int exp);
    $display("%0t ns: %s got 0x%0h, expected 0x%0h", $time, what, got, exp);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    result_t exp;
    if (!rst && strobe) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("unexpected transaction, read_byte", result.read_byte, 0);
      end else begin
        exp = awaited_results.pop_front();
        if (result.read_byte !== exp.read_byte)
          report_mismatch("read_byte", result.read_byte, exp.read_byte);
        if (result.byte_valid !== exp.byte_valid)
          report_mismatch("byte_valid", result.byte_valid, exp.byte_valid);
        if (result.last !== exp.last)
          report_mismatch("last", result.last, exp.last);
        if (result.fill_level !== exp.fill_level)
          report_mismatch("fill_level", result.fill_level, exp.fill_level);
      end
    end
  end

  task automatic send_cmd(input cmd_t c);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      cmd   <= cmd_t'($urandom);
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
    apply_cmd_to_ring(c);
  endtask

  task automatic send_fields(input logic [MODE_W-1:0] mode, input int data, input int len);
    cmd_t c;
    c.mode      = mode;
    c.data_byte = BYTE_W'(data);
    c.max_len   = LEN_IN_W'(len);
    send_cmd(c);
  endtask

  // hold off the sender until every queued result has arrived
  task automatic drain_ring();
    start <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_empty_reads();
    idle_pct = 0;
    send_fields(MODE_READ, 8'hFF, 0);
    send_fields(MODE_READ, 8'h00, 5);
    send_fields(MODE_UNUSED, 8'hFF, 127);
    send_fields(MODE_CLEAR, 8'hFF, 127);
    send_fields(MODE_READ, 8'h00, 127);
    drain_ring();
  endtask

  task automatic test_basic_bursts();
    idle_pct = 0;
    send_fields(MODE_WRITE, 8'h00, 127);
    send_fields(MODE_WRITE, 8'hFF, 0);
    send_fields(MODE_WRITE, 8'hA5, 64);
    send_fields(MODE_READ, 8'hFF, 0);
    send_fields(MODE_UNUSED, 8'h3C, 1);
    send_fields(MODE_READ, 8'h00, 2);
    send_fields(MODE_READ, 8'h00, 127);
    send_fields(MODE_READ, 8'h00, 1);
    send_fields(MODE_WRITE, 8'h5A, 0);
    send_fields(MODE_WRITE, 8'hC3, 0);
    send_fields(MODE_READ, 8'h00, 64);
    drain_ring();
  endtask

  task automatic test_overwrite_when_full();
    idle_pct = 0;
    for (int i = 0; i < RING_DEPTH + 6; i++) send_fields(MODE_WRITE, i ^ 8'h5A, 0);
    send_fields(MODE_READ, 8'h00, 65);
    while (ring_fill > 0) send_fields(MODE_READ, 8'h00, 64);
    send_fields(MODE_READ, 8'h00, 64);
    drain_ring();
  endtask

  task automatic test_clear_mid_stream();
    idle_pct = 0;
    for (int i = 0; i < 20; i++) send_fields(MODE_WRITE, $urandom, $urandom);
    send_fields(MODE_READ, 8'h00, 3);
    send_fields(MODE_CLEAR, 8'h00, 0);
    send_fields(MODE_READ, 8'h00, 3);
    send_fields(MODE_WRITE, 8'h81, 0);
    send_fields(MODE_WRITE, 8'h7E, 0);
    send_fields(MODE_READ, 8'h00, 64);
    drain_ring();
  endtask

  task automatic run_random_traffic(input int pct, input int count);
    int pick;
    int len;
    idle_pct = pct;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        repeat ($urandom_range(8, 2)) send_fields(MODE_WRITE, $urandom, $urandom);
      end else if (pick < 55) begin
        send_fields(MODE_WRITE, $urandom, $urandom);
      end else if (pick < 90) begin
        len = $urandom_range(99);
        if (len < 65) len = $urandom_range(16, 1);
        else if (len < 90) len = $urandom_range(64, 17);
        else len = $urandom_range(127);
        send_fields(MODE_READ, $urandom, len);
      end else if (pick < 95) begin
        send_fields(MODE_CLEAR, $urandom, $urandom);
      end else begin
        send_fields(MODE_UNUSED, $urandom, $urandom);
      end
    end
    drain_ring();
  endtask

  initial begin
    rst            <= 1'b1;
    start          <= 1'b0;
    cmd            <= '0;
    ring_wr        = 0;
    ring_rd        = 0;
    ring_fill      = 0;
    mismatch_count = 0;
    idle_pct       = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_empty_reads();
    test_basic_bursts();
    test_overwrite_when_full();
    test_clear_mid_stream();
    run_random_traffic(0, 50);
    run_random_traffic(75, 50);
    run_random_traffic(27, 50);
    run_random_traffic(0, 30);

    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
